FILE: src/vps_pkg.sv
// ----------------------------------------------------------------------------
// vps_pkg: shared types for the sphere projection block
// Payload structs of both channels and the side record that travels with the
// square-root cell chain.
// ----------------------------------------------------------------------------
package vps_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned MAG_W    = WORD_W + 1;
  localparam int unsigned SUM_W    = 2 * WORD_W;
  localparam int unsigned SQ_REM_W = WORD_W + 2;
  localparam int unsigned Q_W      = WORD_W + 1;
  localparam int unsigned NUM_W    = WORD_W + MAG_W;
  localparam logic [31:0] RADIUS_RESET = 32'h0001_0000;

  typedef struct packed {
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
  } point_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               zero_length;
    logic               saturated;
  } proj_t;

  typedef struct packed {
    logic                        valid;
    logic                        zero;
    logic [2:0]                  neg;
    logic [2:0][MAG_W-1:0]       mag;
  } sqrt_side_t;

endpackage

FILE: src/vps_sqrt_cell.sv
// ----------------------------------------------------------------------------
// vps_sqrt_cell: one digit step of the integer square root
// Takes the next two bits of the radicand, settles one root bit, and hands
// remainder, partial root, radicand and side record to the next cell.
// ----------------------------------------------------------------------------
module vps_sqrt_cell (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  vps_pkg::sqrt_side_t                    side_i,
  input  logic [vps_pkg::SQ_REM_W-1:0]           rem_i,
  input  logic [vps_pkg::WORD_W-1:0]             root_i,
  input  logic [vps_pkg::SUM_W-1:0]              s_i,
  output vps_pkg::sqrt_side_t                    side_o,
  output logic [vps_pkg::SQ_REM_W-1:0]           rem_o,
  output logic [vps_pkg::WORD_W-1:0]             root_o,
  output logic [vps_pkg::SUM_W-1:0]              s_o
);

  logic [vps_pkg::SQ_REM_W+1:0] shifted;
  logic [vps_pkg::SQ_REM_W+1:0] trial;
  logic                         ge;

  assign shifted = {rem_i, s_i[vps_pkg::SUM_W-1 -: 2]};
  assign trial   = {2'b00, root_i, 2'b01};
  assign ge      = shifted >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_o.valid <= 1'b0;
    end else if (en) begin
      side_o.valid <= side_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_o.zero <= side_i.zero;
      side_o.neg  <= side_i.neg;
      side_o.mag  <= side_i.mag;
      rem_o  <= ge ? vps_pkg::SQ_REM_W'(shifted - trial) : vps_pkg::SQ_REM_W'(shifted);
      root_o <= {root_i[vps_pkg::WORD_W-2:0], ge};
      s_o    <= {s_i[vps_pkg::SUM_W-3:0], 2'b00};
    end
  end

endmodule

FILE: src/vps_div_cell.sv
// ----------------------------------------------------------------------------
// vps_div_cell: one restoring step of the length divider
// Shifts one numerator bit into the remainder, settles one quotient bit, and
// hands remainder, quotient, numerator and divisor to the next cell.
// ----------------------------------------------------------------------------
module vps_div_cell (
  input  logic                            clk,
  input  logic                            en,
  input  logic [vps_pkg::WORD_W-1:0]      rem_i,
  input  logic [vps_pkg::Q_W-1:0]         n_i,
  input  logic [vps_pkg::Q_W-1:0]         q_i,
  input  logic [vps_pkg::WORD_W-1:0]      len_i,
  output logic [vps_pkg::WORD_W-1:0]      rem_o,
  output logic [vps_pkg::Q_W-1:0]         n_o,
  output logic [vps_pkg::Q_W-1:0]         q_o,
  output logic [vps_pkg::WORD_W-1:0]      len_o
);

  logic [vps_pkg::WORD_W:0] shifted;
  logic                     ge;

  assign shifted = {rem_i, n_i[vps_pkg::Q_W-1]};
  assign ge      = shifted >= {1'b0, len_i};

  always_ff @(posedge clk) begin
    if (en) begin
      rem_o <= ge ? vps_pkg::WORD_W'(shifted - {1'b0, len_i})
                  : vps_pkg::WORD_W'(shifted);
      q_o   <= {q_i[vps_pkg::Q_W-2:0], ge};
      n_o   <= {n_i[vps_pkg::Q_W-2:0], 1'b0};
      len_o <= len_i;
    end
  end

endmodule

FILE: src/vector_project_to_sphere.sv
// ----------------------------------------------------------------------------
// vector_project_to_sphere: project a Q16.16 point onto a sphere
// Squares, integer square root over a chain of digit cells, radius scaling
// and a chain of restoring divider cells per component, with saturation.
// ----------------------------------------------------------------------------
// The block takes one point per cycle unless stalled and returns each
// projected point through one input stage, one squaring stage, 32 square
// root cells (one root bit each), a radius multiply stage, a rounding stage,
// 33 divider cells per component (one quotient bit each) and the output
// register. A stall on the result side freezes the whole pipeline, so the
// point side sees point_stall while a result beat waits. The radius register
// is written through cfg_valid/cfg_data, which is always ready.
module vector_project_to_sphere (
  input  logic            clk,
  input  logic            rst,
  input  logic            point_valid,
  output logic            point_stall,
  input  vps_pkg::point_t point,
  output logic            proj_valid,
  input  logic            proj_stall,
  output vps_pkg::proj_t  proj,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [31:0]     cfg_data
);

  localparam int unsigned W      = vps_pkg::WORD_W;
  localparam int unsigned MW     = vps_pkg::MAG_W;
  localparam int unsigned SQ_N   = W;
  localparam int unsigned DIV_N  = vps_pkg::Q_W;

  logic        adv;
  logic [31:0] radius;

  assign adv         = !(proj_valid && proj_stall);
  assign point_stall = !adv;
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= vps_pkg::RADIUS_RESET;
    end else if (cfg_valid) begin
      radius <= cfg_data;
    end
  end

  // Input stage: magnitudes and signs.
  logic [W-1:0]         comp [3];
  logic                 s0_valid;
  logic [2:0]           s0_neg;
  logic [2:0][MW-1:0]   s0_mag;

  assign comp[0] = point.in_x;
  assign comp[1] = point.in_y;
  assign comp[2] = point.in_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= point_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s0_neg[k] <= comp[k][W-1];
        s0_mag[k] <= comp[k][W-1] ? MW'(0) - {comp[k][W-1], comp[k]} : {1'b0, comp[k]};
      end
    end
  end

  // Squaring stage.
  logic                           s1_valid;
  logic [2:0]                     s1_neg;
  logic [2:0][MW-1:0]             s1_mag;
  logic [2:0][vps_pkg::SUM_W-2:0] s1_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg <= s0_neg;
      s1_mag <= s0_mag;
      for (int k = 0; k < 3; k++) begin
        s1_sq[k] <= (vps_pkg::SUM_W-1)'(s0_mag[k] * s0_mag[k]);
      end
    end
  end

  // Square root chain.
  logic [vps_pkg::SUM_W-1:0] sum;
  assign sum = {1'b0, s1_sq[0]} + {1'b0, s1_sq[1]} + {1'b0, s1_sq[2]};

  vps_pkg::sqrt_side_t              sq_side [SQ_N+1];
  logic [vps_pkg::SQ_REM_W-1:0]     sq_rem  [SQ_N+1];
  logic [W-1:0]                     sq_root [SQ_N+1];
  logic [vps_pkg::SUM_W-1:0]        sq_s    [SQ_N+1];

  assign sq_side[0].valid = s1_valid;
  assign sq_side[0].zero  = sum == '0;
  assign sq_side[0].neg   = s1_neg;
  assign sq_side[0].mag   = s1_mag;
  assign sq_rem[0]        = '0;
  assign sq_root[0]       = '0;
  assign sq_s[0]          = sum;

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    vps_sqrt_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .side_i (sq_side[i]),
      .rem_i  (sq_rem[i]),
      .root_i (sq_root[i]),
      .s_i    (sq_s[i]),
      .side_o (sq_side[i+1]),
      .rem_o  (sq_rem[i+1]),
      .root_o (sq_root[i+1]),
      .s_o    (sq_s[i+1])
    );
  end

  // Radius multiply stage.
  logic                                m_valid;
  logic                                m_zero;
  logic [2:0]                          m_neg;
  logic [W-1:0]                        m_len;
  logic [2:0][vps_pkg::NUM_W-1:0]      m_num;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= sq_side[SQ_N].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_zero <= sq_side[SQ_N].zero;
      m_neg  <= sq_side[SQ_N].neg;
      m_len  <= sq_root[SQ_N];
      for (int k = 0; k < 3; k++) begin
        m_num[k] <= radius * sq_side[SQ_N].mag[k];
      end
    end
  end

  // Rounding stage: add half the length; a high part at or above the length
  // means the quotient needs more than 33 bits and is clipped anyway.
  logic [2:0][vps_pkg::NUM_W-1:0] rnd;
  logic [2:0]                     rnd_ovf;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd[k]     = m_num[k] + vps_pkg::NUM_W'(m_len >> 1);
      rnd_ovf[k] = rnd[k][vps_pkg::NUM_W-1:DIV_N] >= m_len;
    end
  end

  logic [2:0]   dv_valid [DIV_N+1];
  logic [W-1:0] dv_rem   [3][DIV_N+1];
  logic [DIV_N-1:0] dv_n [3][DIV_N+1];
  logic [DIV_N-1:0] dv_q [3][DIV_N+1];
  logic [W-1:0] dv_len   [3][DIV_N+1];
  logic         dv_zero  [DIV_N+1];
  logic [2:0]   dv_neg   [DIV_N+1];
  logic [2:0]   dv_ovf   [DIV_N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= '0;
    end else if (adv) begin
      dv_valid[0] <= {3{m_valid}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_zero[0] <= m_zero;
      dv_neg[0]  <= m_neg;
      dv_ovf[0]  <= rnd_ovf;
    end
  end

  // Side records that ride along the divider chain.
  for (genvar i = 0; i < DIV_N; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[i+1] <= '0;
      end else if (adv) begin
        dv_valid[i+1] <= dv_valid[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_zero[i+1] <= dv_zero[i];
        dv_neg[i+1]  <= dv_neg[i];
        dv_ovf[i+1]  <= dv_ovf[i];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_rem[k][0] <= rnd_ovf[k] ? '0 : rnd[k][vps_pkg::NUM_W-1:DIV_N];
        dv_n[k][0]   <= rnd[k][DIV_N-1:0];
        dv_q[k][0]   <= '0;
        dv_len[k][0] <= m_len;
      end
    end

    for (genvar i = 0; i < DIV_N; i++) begin : g_div
      vps_div_cell u_cell (
        .clk   (clk),
        .en    (adv),
        .rem_i (dv_rem[k][i]),
        .n_i   (dv_n[k][i]),
        .q_i   (dv_q[k][i]),
        .len_i (dv_len[k][i]),
        .rem_o (dv_rem[k][i+1]),
        .n_o   (dv_n[k][i+1]),
        .q_o   (dv_q[k][i+1]),
        .len_o (dv_len[k][i+1])
      );
    end
  end

  // Sign, clip and output register.
  logic [2:0][W-1:0] res;
  logic [2:0]        clip;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dv_neg[DIV_N][k]) begin
        clip[k] = dv_ovf[DIV_N][k] || (dv_q[k][DIV_N] > DIV_N'(33'h0_8000_0000));
        res[k]  = clip[k] ? 32'h8000_0000 : W'(DIV_N'(0) - dv_q[k][DIV_N]);
      end else begin
        clip[k] = dv_ovf[DIV_N][k] || (dv_q[k][DIV_N] > DIV_N'(33'h0_7FFF_FFFF));
        res[k]  = clip[k] ? 32'h7FFF_FFFF : dv_q[k][DIV_N][W-1:0];
      end
      if (dv_zero[DIV_N]) begin
        clip[k] = 1'b0;
        res[k]  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      proj_valid <= 1'b0;
    end else if (adv) begin
      proj_valid <= dv_valid[DIV_N][0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      proj.out_x       <= res[0];
      proj.out_y       <= res[1];
      proj.out_z       <= res[2];
      proj.zero_length <= dv_zero[DIV_N];
      proj.saturated   <= |clip;
    end
  end

`ifndef SYNTHESIS
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    proj_valid && proj.zero_length |->
      proj.out_x == 0 && proj.out_y == 0 && proj.out_z == 0 && !proj.saturated)
    else $error("zero-length result with nonzero fields");

  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    proj_valid && proj.saturated |->
      proj.out_x == 32'h7FFF_FFFF || proj.out_x == 32'h8000_0000 ||
      proj.out_y == 32'h7FFF_FFFF || proj.out_y == 32'h8000_0000 ||
      proj.out_z == 32'h7FFF_FFFF || proj.out_z == 32'h8000_0000)
    else $error("saturated flag without a clipped component");

  a_lanes_agree: assert property (@(posedge clk) disable iff (rst)
    dv_valid[DIV_N] == 3'b000 || dv_valid[DIV_N] == 3'b111)
    else $error("divider lanes out of step");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !proj_valid)
    else $error("result beat right after reset");
`endif

endmodule
